FILE: hw/rtl/pcnl_pkg.sv
// Shared types and constants for the periodic cell neighbor list block.
`timescale 1ns / 1ps
package pcnl_pkg;

  localparam int CELL_W  = 18;
  localparam int CNT_W   = 7;
  localparam int AXIS_W  = 6;
  localparam int SLOT_W  = 5;
  localparam int IDX_W   = 3;
  localparam int MID_W   = 12;
  localparam logic [CNT_W-1:0] MAX_CELLS = 7'd64;

  localparam logic [IDX_W-1:0] REG_CELLS_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELLS_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELLS_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_REACH_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_REACH_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_REACH_Z = 3'd5;

  // effective grid settings, counts saturated to 1..64
  typedef struct packed {
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
    logic [CNT_W-1:0] nz;
    logic             rx;
    logic             ry;
    logic             rz;
  } cfg_t;

  // decomposed center cell
  typedef struct packed {
    logic [AXIS_W-1:0] cx;
    logic [AXIS_W-1:0] cy;
    logic [AXIS_W-1:0] cz;
    logic              err;
  } item_t;

endpackage

FILE: hw/rtl/periodic_cell_neighbor_list.sv
// Top level of the periodic cell neighbor list: config registers, front, queue, back.
//
// Usage: push a linear cell index (z fastest) while full is low. The block returns
// the wrapped linear index of every neighbor cell, x offset outermost and z innermost,
// one result per transfer on the output queue side: a result is valid while empty is
// low and leaves at a clock edge with pop high. The final result of each cell has
// last_neighbor set; an index outside the grid gives one result with index_error set.
// Grid size and reach are written through cfg_valid/cfg_ready/cfg_index/cfg_data while
// the block is idle; cfg_ready is always high, indexes past the six registers are
// ignored.
// Throughput: the front divider works on one cell at a time and takes no new push
// until it has handed that cell off (two 18-bit divisions at three quotient bits per
// cycle, plus load and hand-off); the back emits one result per cycle while pop is high.
// A full cell has 27 results; the divider work of the next cell overlaps them through
// a two-entry queue.
// Reset clears all pending work and sets every axis count to 1 and every reach to 1.
// When pop stays low the back stalls on its output register; the front keeps
// decomposing until the queue is full, then holds its finished cell with full high.
`timescale 1ns / 1ps
module periodic_cell_neighbor_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcnl_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pcnl_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [pcnl_pkg::CELL_W-1:0]   cell_index,
  output logic                          empty,
  input  logic                          pop,
  output logic [pcnl_pkg::CELL_W-1:0]   neighbor_index,
  output logic [pcnl_pkg::SLOT_W-1:0]   neighbor_slot,
  output logic                          last_neighbor,
  output logic                          index_error
);

  logic [pcnl_pkg::CNT_W-1:0] cells_x, cells_y, cells_z;
  logic                       reach_x, reach_y, reach_z;
  pcnl_pkg::cfg_t             cfg;
  logic                       q_push, q_full, q_pop, q_valid;
  pcnl_pkg::item_t            front_item, back_item;

  function automatic logic [pcnl_pkg::CNT_W-1:0] sat_cells(
    input logic [pcnl_pkg::CNT_W-1:0] v
  );
    logic [pcnl_pkg::CNT_W-1:0] res;
    if (v == '0) res = 7'd1;
    else if (v > pcnl_pkg::MAX_CELLS) res = pcnl_pkg::MAX_CELLS;
    else res = v;
    return res;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= 7'd1;
      cells_y <= 7'd1;
      cells_z <= 7'd1;
      reach_x <= 1'b1;
      reach_y <= 1'b1;
      reach_z <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcnl_pkg::REG_CELLS_X: cells_x <= cfg_data;
        pcnl_pkg::REG_CELLS_Y: cells_y <= cfg_data;
        pcnl_pkg::REG_CELLS_Z: cells_z <= cfg_data;
        pcnl_pkg::REG_REACH_X: reach_x <= cfg_data[0];
        pcnl_pkg::REG_REACH_Y: reach_y <= cfg_data[0];
        pcnl_pkg::REG_REACH_Z: reach_z <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.nx = sat_cells(cells_x);
    cfg.ny = sat_cells(cells_y);
    cfg.nz = sat_cells(cells_z);
    cfg.rx = reach_x;
    cfg.ry = reach_y;
    cfg.rz = reach_z;
  end

  pcnl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .cell_index (cell_index),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_item     (front_item)
  );

  pcnl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (front_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_valid (q_valid),
    .rd_item (back_item)
  );

  pcnl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (back_item),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .neighbor_index (neighbor_index),
    .neighbor_slot  (neighbor_slot),
    .last_neighbor  (last_neighbor),
    .index_error    (index_error)
  );

endmodule

FILE: hw/rtl/pcnl_front.sv
// Front end: takes a linear index and splits it into x, y, z with a radix-2 divider.
`timescale 1ns / 1ps
module pcnl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  pcnl_pkg::cfg_t                    cfg,
  input  logic                              push,
  output logic                              full,
  input  logic [pcnl_pkg::CELL_W-1:0]       cell_index,
  output logic                              q_push,
  input  logic                              q_full,
  output pcnl_pkg::item_t                   q_item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV_Z = 2'd1;
  localparam logic [1:0] ST_DIV_Y = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int BITS_PER_STEP = 3;
  localparam int DIV_STEPS = pcnl_pkg::CELL_W / BITS_PER_STEP;
  localparam logic [2:0] LAST_STEP = 3'(DIV_STEPS - 1);

  logic [1:0]                    state;
  logic [2:0]                    step;
  logic [pcnl_pkg::CELL_W-1:0]   quo;
  logic [pcnl_pkg::AXIS_W-1:0]   rem;
  logic [pcnl_pkg::CELL_W-1:0]   quo_next;
  logic [pcnl_pkg::AXIS_W-1:0]   rem_next;
  logic [pcnl_pkg::CNT_W-1:0]    divisor;
  pcnl_pkg::item_t               result;

  always_comb begin
    logic [pcnl_pkg::CNT_W-1:0] r;
    quo_next = quo;
    rem_next = rem;
    divisor  = (state == ST_DIV_Y) ? cfg.ny : cfg.nz;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r = {rem_next, quo_next[pcnl_pkg::CELL_W-1]};
      if (r >= divisor) begin
        r = r - divisor;
        quo_next = {quo_next[pcnl_pkg::CELL_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[pcnl_pkg::CELL_W-2:0], 1'b0};
      end
      rem_next = r[pcnl_pkg::AXIS_W-1:0];
    end
  end

  assign full   = (state != ST_IDLE);
  assign q_push = (state == ST_DONE) && !q_full;
  assign q_item = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) state <= ST_DIV_Z;
        end
        ST_DIV_Z: begin
          if (step == LAST_STEP) state <= ST_DIV_Y;
        end
        ST_DIV_Y: begin
          if (step == LAST_STEP) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!q_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      quo  <= cell_index;
      rem  <= '0;
      step <= '0;
    end else if (state == ST_DIV_Z || state == ST_DIV_Y) begin
      if (step == LAST_STEP) begin
        step <= '0;
        rem  <= '0;
        if (state == ST_DIV_Z) begin
          quo       <= quo_next;
          result.cz <= rem_next;
        end else begin
          result.cy  <= rem_next;
          result.cx  <= quo_next[pcnl_pkg::AXIS_W-1:0];
          result.err <= (quo_next >= pcnl_pkg::CELL_W'(cfg.nx));
        end
      end else begin
        step <= step + 3'd1;
        quo  <= quo_next;
        rem  <= rem_next;
      end
    end
  end

endmodule

FILE: hw/rtl/pcnl_queue.sv
// Two-entry queue of decomposed cells between the front and back ends.
`timescale 1ns / 1ps
module pcnl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  pcnl_pkg::item_t wr_item,
  output logic            q_full,
  input  logic            rd,
  output logic            q_valid,
  output pcnl_pkg::item_t rd_item
);

  pcnl_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      if (wr && !rd) count <= count + 2'd1;
      else if (rd && !wr) count <= count - 2'd1;
    end
  end

endmodule

FILE: hw/rtl/pcnl_back.sv
// Back end: walks the neighbor offsets and forms wrapped linear indices in two stages.
`timescale 1ns / 1ps
module pcnl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pcnl_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  pcnl_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [pcnl_pkg::CELL_W-1:0]   neighbor_index,
  output logic [pcnl_pkg::SLOT_W-1:0]   neighbor_slot,
  output logic                          last_neighbor,
  output logic                          index_error
);

  function automatic logic [pcnl_pkg::AXIS_W-1:0] wrap_step(
    input logic [pcnl_pkg::AXIS_W-1:0] c,
    input logic [1:0]                  o,
    input logic [pcnl_pkg::CNT_W-1:0]  n
  );
    logic [pcnl_pkg::CNT_W-1:0] top;
    logic [pcnl_pkg::AXIS_W-1:0] res;
    top = n - 7'd1;
    case (o)
      2'd0:    res = (c == '0) ? top[pcnl_pkg::AXIS_W-1:0] : c - 6'd1;
      2'd2:    res = ({1'b0, c} == top) ? '0 : c + 6'd1;
      default: res = c;
    endcase
    return res;
  endfunction

  logic                        en;
  logic                        busy;
  logic                        load;
  logic                        gen_last;
  pcnl_pkg::item_t             cur;
  logic [1:0]                  ox, oy, oz;
  logic [1:0]                  lo_x, lo_y, lo_z;
  logic [1:0]                  hi_x, hi_y, hi_z;
  logic [pcnl_pkg::SLOT_W-1:0] slot;
  logic [pcnl_pkg::AXIS_W-1:0] ux, uy, uz;

  logic                        a_v;
  logic [pcnl_pkg::MID_W-1:0]  a_mid;
  logic [pcnl_pkg::AXIS_W-1:0] a_uz;
  logic [pcnl_pkg::SLOT_W-1:0] a_slot;
  logic                        a_last;
  logic                        a_err;

  logic                        b_v;
  logic [pcnl_pkg::MID_W+pcnl_pkg::CNT_W-1:0]  b_prod;
  logic [pcnl_pkg::AXIS_W+pcnl_pkg::CNT_W-1:0] a_prod;

  assign lo_x = cfg.rx ? 2'd0 : 2'd1;
  assign lo_y = cfg.ry ? 2'd0 : 2'd1;
  assign lo_z = cfg.rz ? 2'd0 : 2'd1;
  assign hi_x = cfg.rx ? 2'd2 : 2'd1;
  assign hi_y = cfg.ry ? 2'd2 : 2'd1;
  assign hi_z = cfg.rz ? 2'd2 : 2'd1;

  assign en       = !b_v || pop;
  assign gen_last = cur.err || ((ox == hi_x) && (oy == hi_y) && (oz == hi_z));
  assign load     = en && q_valid && (!busy || gen_last);
  assign q_pop    = load;

  assign ux = wrap_step(cur.cx, ox, cfg.nx);
  assign uy = wrap_step(cur.cy, oy, cfg.ny);
  assign uz = wrap_step(cur.cz, oz, cfg.nz);

  assign a_prod = {{pcnl_pkg::CNT_W{1'b0}}, ux} * {{pcnl_pkg::AXIS_W{1'b0}}, cfg.ny};
  assign b_prod = {{pcnl_pkg::CNT_W{1'b0}}, a_mid} * {{pcnl_pkg::MID_W{1'b0}}, cfg.nz};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      a_v  <= 1'b0;
      b_v  <= 1'b0;
    end else if (en) begin
      if (load) busy <= 1'b1;
      else if (busy && gen_last) busy <= 1'b0;
      a_v <= busy;
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= q_item;
      ox   <= lo_x;
      oy   <= lo_y;
      oz   <= lo_z;
      slot <= '0;
    end else if (en && busy && !gen_last) begin
      slot <= slot + 5'd1;
      if (oz != hi_z) begin
        oz <= oz + 2'd1;
      end else begin
        oz <= lo_z;
        if (oy != hi_y) begin
          oy <= oy + 2'd1;
        end else begin
          oy <= lo_y;
          ox <= ox + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_last <= gen_last;
      a_err  <= cur.err;
      if (cur.err) begin
        a_mid  <= '0;
        a_uz   <= '0;
        a_slot <= '0;
      end else begin
        a_mid  <= pcnl_pkg::MID_W'(a_prod + {{pcnl_pkg::CNT_W{1'b0}}, uy});
        a_uz   <= uz;
        a_slot <= slot;
      end
      neighbor_index <= pcnl_pkg::CELL_W'(b_prod + {{pcnl_pkg::MID_W{1'b0}},
                                                    {1'b0, a_uz}});
      neighbor_slot  <= a_slot;
      last_neighbor  <= a_last;
      index_error    <= a_err;
    end
  end

  assign empty = !b_v;

endmodule
